// File: hdl/vmde_pkg.sv
package vmde_pkg;

  // Volume geometry
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned ROW_WORDS = 4;
  localparam int unsigned ROWS      = 64;
  localparam int unsigned PLANES    = 64;

  localparam int unsigned BX_W   = $clog2(ROW_WORDS);
  localparam int unsigned Y_W    = $clog2(ROWS);
  localparam int unsigned Z_W    = $clog2(PLANES);
  localparam int unsigned ADDR_W = Z_W + Y_W + BX_W;
  localparam int unsigned DEPTH  = PLANES * ROWS * ROW_WORDS;
  localparam int unsigned PAD_W  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // Item kind carried on tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_X_SIZE = 2'd1;
  localparam logic [1:0] REG_Y_SIZE = 2'd2;
  localparam logic [1:0] REG_Z_SIZE = 2'd3;

  // Fetch order of the source word and its neighbours
  typedef enum logic [2:0] {
    NB_CENTER = 3'd0,
    NB_XNEXT  = 3'd1,
    NB_XPREV  = 3'd2,
    NB_YDN    = 3'd3,
    NB_YUP    = 3'd4,
    NB_ZDN    = 3'd5,
    NB_ZUP    = 3'd6
  } nb_e;

  localparam logic [2:0] NB_COUNT = 3'd7;

  // Store access request
  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

  // Saturated geometry, derived from the registers
  typedef struct packed {
    logic             erode;
    logic [2:0]       nbx;
    logic [6:0]       ys;
    logic [6:0]       zs;
    logic [PAD_W-1:0] pad;
  } geom_t;

endpackage

// File: hdl/vmde_store.sv
module vmde_store
  import vmde_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output word_t    rd_data_o
);

  word_t mem [DEPTH];
  word_t rd_data_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rd_data_q <= mem[req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/vmde_alu.sv
module vmde_alu
  import vmde_pkg::*;
(
  input  logic  erode_i,
  input  word_t acc_i,
  input  word_t opnd_i,
  output word_t res_o
);

  // Erode folds with AND, dilate with OR
  assign res_o = erode_i ? (acc_i & opnd_i) : (acc_i | opnd_i);

endmodule

// File: hdl/vmde_seq.sv
module vmde_seq
  import vmde_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  geom_t                 geom_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic                  s_kind_i,
  input  logic [BX_W-1:0]       s_bx_i,
  input  logic [Y_W-1:0]        s_y_i,
  input  logic [Z_W-1:0]        s_z_i,
  input  word_t                 s_word_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output word_t                 m_word_o,
  output mem_req_t              mem_req_o,
  input  word_t                 mem_rd_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_FIN_L,
    ST_FIN_R,
    ST_OUT
  } state_e;

  state_e          state_q, state_d;
  addr_t           clr_q, clr_d;
  logic [2:0]      step_q, step_d;
  logic            pend_q, pend_d;
  nb_e             tag_q, tag_d;
  logic [BX_W-1:0] bx_q, bx_d;
  logic [Y_W-1:0]  y_q, y_d;
  logic [Z_W-1:0]  z_q, z_d;
  logic            last_q, last_d;
  word_t           acc_q, acc_d;
  word_t           src_q, src_d;
  logic            cl_q, cl_d;
  logic            cr_q, cr_d;
  logic            ovld_q, ovld_d;
  word_t           odat_q, odat_d;

  word_t           alu_opnd, alu_res, pad_mask;
  logic            accept, present;
  logic            in_vol, bound, x_next_ok;
  addr_t           rd_addr;

  vmde_alu u_alu (
    .erode_i (geom_i.erode),
    .acc_i   (acc_q),
    .opnd_i  (alu_opnd),
    .res_o   (alu_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_word_o      = odat_q;

  assign in_vol = ({1'b0, s_bx_i} < geom_i.nbx) && ({1'b0, s_y_i} < geom_i.ys)
               && ({1'b0, s_z_i} < geom_i.zs);
  assign bound  = (s_y_i == '0) || (s_z_i == '0)
               || ({1'b0, s_y_i} == geom_i.ys - 7'd1)
               || ({1'b0, s_z_i} == geom_i.zs - 7'd1);
  assign x_next_ok = ({1'b0, bx_q} + 3'd1) < geom_i.nbx;

  assign pad_mask = ~word_t'(0) << geom_i.pad;

  // Neighbour address and presence for the current step
  always_comb begin
    rd_addr = {z_q, y_q, bx_q};
    present = 1'b0;
    unique case (step_q)
      NB_CENTER: begin
        present = 1'b1;
      end
      NB_XNEXT: begin
        rd_addr = {z_q, y_q, bx_q + BX_W'(1)};
        present = x_next_ok;
      end
      NB_XPREV: begin
        rd_addr = {z_q, y_q, bx_q - BX_W'(1)};
        present = (bx_q != '0);
      end
      NB_YDN: begin
        rd_addr = {z_q, y_q - Y_W'(1), bx_q};
        present = (y_q != '0);
      end
      NB_YUP: begin
        rd_addr = {z_q, y_q + Y_W'(1), bx_q};
        present = ({1'b0, y_q} + 7'd1) < geom_i.ys;
      end
      NB_ZDN: begin
        rd_addr = {z_q - Z_W'(1), y_q, bx_q};
        present = (z_q != '0);
      end
      NB_ZUP: begin
        rd_addr = {z_q + Z_W'(1), y_q, bx_q};
        present = ({1'b0, z_q} + 7'd1) < geom_i.zs;
      end
      default: begin
        present = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_FIN_L: alu_opnd = {src_q[WORD_BITS-2:0], cl_q};
      ST_FIN_R: alu_opnd = {cr_q, src_q[WORD_BITS-1:1]};
      default:  alu_opnd = mem_rd_i;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    step_d    = step_q;
    pend_d    = 1'b0;
    tag_d     = tag_q;
    bx_d      = bx_q;
    y_d       = y_q;
    z_d       = z_q;
    last_d    = last_q;
    acc_d     = acc_q;
    src_d     = src_q;
    cl_d      = cl_q;
    cr_d      = cr_q;
    ovld_d    = ovld_q && !m_axis_tready;
    odat_d    = odat_q;
    mem_req_o = '{en: 1'b0, we: 1'b0, addr: rd_addr, wdata: s_word_i};

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o = '{en: 1'b1, we: 1'b1, addr: clr_q, wdata: '0};
        clr_d     = clr_q + addr_t'(1);
        if (clr_q == addr_t'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_kind_i == KIND_LOAD) begin
            mem_req_o = '{en: 1'b1, we: 1'b1, addr: {s_z_i, s_y_i, s_bx_i},
                          wdata: s_word_i};
          end else begin
            bx_d   = s_bx_i;
            y_d    = s_y_i;
            z_d    = s_z_i;
            step_d = '0;
            cl_d   = 1'b0;
            cr_d   = 1'b0;
            last_d = ({1'b0, s_bx_i} + 3'd1) == geom_i.nbx;
            if (!in_vol || (geom_i.erode && bound)) begin
              acc_d   = '0;
              last_d  = 1'b0;
              state_d = ST_OUT;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        // Fold the word read in the previous cycle
        if (pend_q) begin
          unique case (tag_q)
            NB_CENTER: begin
              acc_d = mem_rd_i;
              src_d = mem_rd_i;
            end
            NB_XNEXT: cl_d  = mem_rd_i[WORD_BITS-1];
            NB_XPREV: cr_d  = mem_rd_i[0];
            default:  acc_d = alu_res;
          endcase
        end
        if (step_q < NB_COUNT) begin
          if (present) begin
            mem_req_o.en = 1'b1;
            pend_d       = 1'b1;
            tag_d        = nb_e'(step_q);
          end
          step_d = step_q + 3'd1;
        end else if (!pend_q) begin
          state_d = ST_FIN_L;
        end
      end
      ST_FIN_L: begin
        acc_d   = alu_res;
        state_d = ST_FIN_R;
      end
      ST_FIN_R: begin
        acc_d   = alu_res;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          odat_d  = (!geom_i.erode && last_q) ? (acc_q & pad_mask) : acc_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    bx_q   <= bx_d;
    y_q    <= y_d;
    z_q    <= z_d;
    last_q <= last_d;
    acc_q  <= acc_d;
    src_q  <= src_d;
    cl_q   <= cl_d;
    cr_q   <= cr_d;
    odat_q <= odat_d;
  end

endmodule

// File: hdl/voxel_morphology_dilate_erode.sv
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid tready tuser tdata    load or query item
// m_axis    out  tvalid tready tdata          result word of a query
// cfg       in   cfg_we_i cfg_index_i         register write, no read-back
//
// A load is written to the store on acceptance; tready stays high. A query
// walks seven fetch slots (word, then x, y, z neighbours) on the single store
// port and folds the two x-shifted copies through the shared AND/OR unit.
// Out-of-volume or erode-boundary queries skip the fetches and give a zero
// word. After reset the store is zeroed, one word per cycle, with tready low.
// A result waits in the output register; a query ending then stalls.
module voxel_morphology_dilate_erode
  import vmde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // kind
  input  logic [79:0] s_axis_tdata,   // block_x[1:0] row_y[7:2] plane_z[13:8]
                                      // load_word[77:14], zero[79:78]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // result_word
);

  logic       mode_q;
  logic [8:0] x_size_q;
  logic [6:0] y_size_q;
  logic [6:0] z_size_q;

  logic [8:0] xs;
  logic [8:0] xs_up;
  logic [6:0] ys, zs;
  geom_t      geom;
  mem_req_t   mem_req;
  word_t      mem_rd;
  word_t      m_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      x_size_q <= 9'd256;
      y_size_q <= 7'd64;
      z_size_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_X_SIZE: x_size_q <= cfg_data_i;
        REG_Y_SIZE: y_size_q <= cfg_data_i[6:0];
        REG_Z_SIZE: z_size_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to the store extent; a zero size becomes one
  always_comb begin
    if (x_size_q == '0) begin
      xs = 9'd1;
    end else if (x_size_q > 9'(WORD_BITS * ROW_WORDS)) begin
      xs = 9'(WORD_BITS * ROW_WORDS);
    end else begin
      xs = x_size_q;
    end
    if (y_size_q == '0) begin
      ys = 7'd1;
    end else if (y_size_q > 7'(ROWS)) begin
      ys = 7'(ROWS);
    end else begin
      ys = y_size_q;
    end
    if (z_size_q == '0) begin
      zs = 7'd1;
    end else if (z_size_q > 7'(PLANES)) begin
      zs = 7'(PLANES);
    end else begin
      zs = z_size_q;
    end
  end

  assign xs_up      = xs + 9'(WORD_BITS - 1);
  assign geom.erode = mode_q;
  assign geom.nbx   = xs_up[8:PAD_W];
  assign geom.ys    = ys;
  assign geom.zs    = zs;
  // padding bits in the last word of a row
  assign geom.pad   = PAD_W'(7'(WORD_BITS) - {1'b0, xs[PAD_W-1:0]});

  vmde_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  vmde_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_kind_i      (s_axis_tuser),
    .s_bx_i        (s_axis_tdata[1:0]),
    .s_y_i         (s_axis_tdata[7:2]),
    .s_z_i         (s_axis_tdata[13:8]),
    .s_word_i      (s_axis_tdata[77:14]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_word_o      (m_word),
    .mem_req_o     (mem_req),
    .mem_rd_i      (mem_rd)
  );

  assign m_axis_tdata = m_word;

endmodule

// File: hdl/vmde_checker.sv
module vmde_checker
  import vmde_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic load_acc, query_acc;

  assign load_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD);
  assign query_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY);

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> s_axis_tready)
    else $error("input not ready after a load transaction");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> !s_axis_tready)
    else $error("input ready right after a query transaction");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_acc && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result shown in the cycle after a query");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind voxel_morphology_dilate_erode vmde_checker u_vmde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/voxel_morphology_dilate_erode_tb.sv
module voxel_morphology_dilate_erode_tb;
  import vmde_pkg::*;

  // Clearing pass plus a few hundred items at worst-case stalls, many times over
  localparam int unsigned LIMIT  = 400000;
  // Quiet cycles after the last result: longest query path plus margin
  localparam int unsigned SETTLE = 16;

  typedef enum int unsigned {SINK_OPEN, SINK_RANDOM, SINK_PULSED} sink_e;

  // Mirror of the voxel store and registers; predicts each query's word
  class morph_board;
    word_t       shadow_words [DEPTH];
    word_t       awaited_words [$];
    bit          erode;
    int unsigned x_reg, y_reg, z_reg;
    int unsigned errors;

    function new();
      foreach (shadow_words[i]) shadow_words[i] = '0;
      erode  = 1'b0;
      x_reg  = 256;
      y_reg  = 64;
      z_reg  = 64;
      errors = 0;
    endfunction

    static function int unsigned sat(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned slot(int unsigned bx, int unsigned y, int unsigned z);
      return (z * ROWS + y) * ROW_WORDS + bx;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        REG_MODE:   erode = val[0];
        REG_X_SIZE: x_reg = val;
        REG_Y_SIZE: y_reg = val[6:0];
        REG_Z_SIZE: z_reg = val[6:0];
        default: ;
      endcase
    endfunction

    function word_t morph_of(int unsigned bx, int unsigned y, int unsigned z);
      int unsigned xs, ys, zs, nbx, pad;
      word_t src, lft, rgt, acc;
      xs  = sat(x_reg, WORD_BITS * ROW_WORDS);
      ys  = sat(y_reg, ROWS);
      zs  = sat(z_reg, PLANES);
      nbx = (xs + WORD_BITS - 1) / WORD_BITS;
      if (bx >= nbx || y >= ys || z >= zs) return '0;
      src = shadow_words[slot(bx, y, z)];
      // x shifts, with the edge voxel carried in from the adjacent word
      lft = src << 1;
      rgt = src >> 1;
      if (bx + 1 < nbx) lft[0] = shadow_words[slot(bx + 1, y, z)][WORD_BITS-1];
      if (bx > 0) rgt[WORD_BITS-1] = shadow_words[slot(bx - 1, y, z)][0];
      if (!erode) begin
        acc = src | lft | rgt;
        if (y >= 1) acc |= shadow_words[slot(bx, y - 1, z)];
        if (y + 1 < ys) acc |= shadow_words[slot(bx, y + 1, z)];
        if (z >= 1) acc |= shadow_words[slot(bx, y, z - 1)];
        if (z + 1 < zs) acc |= shadow_words[slot(bx, y, z + 1)];
        // padding past x_size sits in the low bits of the last word
        pad = (WORD_BITS - xs % WORD_BITS) % WORD_BITS;
        if (bx + 1 == nbx) acc &= ~((word_t'(1) << pad) - word_t'(1));
        return acc;
      end
      // erosion: any y/z boundary row is empty
      if (y == 0 || z == 0 || y == ys - 1 || z == zs - 1) return '0;
      return src & lft & rgt
           & shadow_words[slot(bx, y - 1, z)] & shadow_words[slot(bx, y + 1, z)]
           & shadow_words[slot(bx, y, z - 1)] & shadow_words[slot(bx, y, z + 1)];
    endfunction

    function void take_item(logic kind, int unsigned bx, int unsigned y, int unsigned z,
                            word_t w);
      if (kind == KIND_LOAD) shadow_words[slot(bx, y, z)] = w;
      else awaited_words.push_back(morph_of(bx, y, z));
    endfunction

    function void match_result(word_t got);
      word_t want;
      if (awaited_words.size() == 0) begin
        errors++;
        $error("result_word: expected none, actual %h", got);
        return;
      end
      want = awaited_words.pop_front();
      if (got !== want) begin
        errors++;
        $error("result_word: expected %h, actual %h", want, got);
      end
    endfunction

    function int unsigned pending();
      return awaited_words.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = REG_MODE;
  logic [8:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser  = KIND_LOAD;  // kind
  logic [79:0] s_axis_tdata  = '0;         // block_x, row_y, plane_z, load_word, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;               // result_word

  morph_board  board;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned sent        = 0;
  bit          steady      = 1'b0;
  sink_e       sink_mode   = SINK_OPEN;
  int unsigned sink_tick   = 0;

  voxel_morphology_dilate_erode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("voxel_morphology_dilate_erode_tb: done, errors");
      $finish;
    end
  end

  // Result side: check each transaction, ready follows a slowly changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) board.match_result(m_axis_tdata);
    if (sink_tick % 97 == 0) sink_mode = sink_e'($urandom_range(0, 2));
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:   m_axis_tready <= 1'b1;
      SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:     m_axis_tready <= ((sink_tick % 9) < 4);
    endcase
  end

  function automatic word_t fill_word(bit dense);
    word_t r;
    r = {$urandom, $urandom};
    if (dense) begin
      case ($urandom_range(0, 3))
        0:       return '1;
        1:       return ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
        2:       return r | {$urandom, $urandom} | {$urandom, $urandom};
        default: return r | {$urandom, $urandom};
      endcase
    end
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return r;
      2:       return r & {$urandom, $urandom};
      3:       return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
      default: return '1;
    endcase
  endfunction

  // One input transaction; gaps come between bursts unless the phase is steady
  task automatic send_item(logic kind, int unsigned bx, int unsigned y, int unsigned z,
                           word_t w);
    if (!steady && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, w, 6'(z), 6'(y), 2'(bx)};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.take_item(kind, bx, y, z, w);
    sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic set_regs(bit mode, int unsigned xs, int unsigned ys, int unsigned zs);
    cfg_write(REG_MODE, 9'(mode));
    cfg_write(REG_X_SIZE, 9'(xs));
    cfg_write(REG_Y_SIZE, 9'(ys));
    cfg_write(REG_Z_SIZE, 9'(zs));
    cfg_we_i <= 1'b0;
  endtask

  // Wait out all queries, then a quiet settle interval
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly: fill a word's six-neighbourhood, then query it. Rest: scattered noise.
  task automatic random_phase(bit mode, int unsigned xs, int unsigned ys, int unsigned zs,
                              int unsigned count);
    int unsigned xe, ye, ze, nbx, start, bx, y, z;
    int nx, ny, nz;
    bit dense;
    int dx [6] = '{-1, 1, 0, 0, 0, 0};
    int dy [6] = '{0, 0, -1, 1, 0, 0};
    int dz [6] = '{0, 0, 0, 0, -1, 1};
    set_regs(mode, xs, ys, zs);
    xe    = morph_board::sat(xs, WORD_BITS * ROW_WORDS);
    ye    = morph_board::sat(ys, ROWS);
    ze    = morph_board::sat(zs, PLANES);
    nbx   = (xe + WORD_BITS - 1) / WORD_BITS;
    steady     = ($urandom_range(0, 3) == 0);
    burst_left = 0;
    start = sent;
    while (sent - start < count) begin
      if ($urandom_range(0, 9) < 7) begin
        bx = $urandom_range(0, nbx - 1);
        y  = $urandom_range(0, ye - 1);
        z  = $urandom_range(0, ze - 1);
        // erosion only shows anything away from the y/z faces
        if (mode && $urandom_range(0, 3) != 0) begin
          if (ye > 2) y = $urandom_range(1, ye - 2);
          if (ze > 2) z = $urandom_range(1, ze - 2);
        end
        dense = mode || ($urandom_range(0, 1) != 0);
        send_item(KIND_LOAD, bx, y, z, fill_word(dense));
        for (int k = 0; k < 6; k++) begin
          nx = int'(bx) + dx[k];
          ny = int'(y) + dy[k];
          nz = int'(z) + dz[k];
          if (nx >= 0 && nx < ROW_WORDS && ny >= 0 && ny < ROWS && nz >= 0 && nz < PLANES &&
              $urandom_range(0, 7) != 0)
            send_item(KIND_LOAD, nx, ny, nz, fill_word(dense));
        end
        send_item(KIND_QUERY, bx, y, z, {$urandom, $urandom});
        if ($urandom_range(0, 2) == 0) begin
          nx = int'(bx) + dx[$urandom_range(0, 5)];
          if (nx >= 0 && nx < ROW_WORDS) send_item(KIND_QUERY, nx, y, z, {$urandom, $urandom});
        end
      end else begin
        send_item(($urandom_range(0, 1) != 0) ? KIND_QUERY : KIND_LOAD,
                  $urandom_range(0, ROW_WORDS - 1), $urandom_range(0, ROWS - 1),
                  $urandom_range(0, PLANES - 1), fill_word($urandom_range(0, 1) != 0));
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset registers: dilate over 256 x 64 x 64
    send_item(KIND_QUERY, 0, 0, 0, '1);                      // empty store
    send_item(KIND_LOAD, 3, 63, 63, '1);
    send_item(KIND_QUERY, 3, 63, 63, '0);                    // all-ones word stays all ones
    send_item(KIND_LOAD, 1, 10, 20, 64'h8000_0000_0000_0001);
    send_item(KIND_LOAD, 0, 10, 20, 64'h0000_0000_0000_0001); // carries into next word's MSB
    send_item(KIND_LOAD, 2, 10, 20, 64'h8000_0000_0000_0000); // carries into prior word's LSB
    send_item(KIND_LOAD, 1, 9, 20, {$urandom, $urandom});
    send_item(KIND_LOAD, 1, 11, 20, {$urandom, $urandom});
    send_item(KIND_LOAD, 1, 10, 19, {$urandom, $urandom});
    send_item(KIND_LOAD, 1, 10, 21, {$urandom, $urandom});
    send_item(KIND_QUERY, 1, 10, 20, {$urandom, $urandom});
    send_item(KIND_QUERY, 0, 10, 20, {$urandom, $urandom});
    send_item(KIND_QUERY, 2, 10, 20, {$urandom, $urandom});
    drain();

    // Directed erosion: a full neighbourhood survives, faces give zero
    set_regs(1'b1, 256, 64, 64);
    send_item(KIND_LOAD, 1, 30, 30, '1);
    send_item(KIND_LOAD, 0, 30, 30, '1);
    send_item(KIND_LOAD, 2, 30, 30, '1);
    send_item(KIND_LOAD, 1, 29, 30, '1);
    send_item(KIND_LOAD, 1, 31, 30, '1);
    send_item(KIND_LOAD, 1, 30, 29, '1);
    send_item(KIND_LOAD, 1, 30, 31, '1);
    send_item(KIND_QUERY, 1, 30, 30, '0);
    send_item(KIND_QUERY, 1, 0, 5, '0);
    send_item(KIND_QUERY, 1, 30, 63, '0);
    drain();

    random_phase(1'b0, 256, 64, 64, 44);
    random_phase(1'b1, 256, 64, 64, 44);
    random_phase(1'b0, 1, 1, 1, 44);
    random_phase(1'b1, 1, 1, 1, 30);
    random_phase(1'b0, 65, 3, 3, 44);
    random_phase(1'b1, 130, 5, 4, 44);
    random_phase(1'b0, 0, 0, 0, 40);      // zero sizes saturate to one
    random_phase(1'b1, 511, 127, 127, 44); // oversize saturates to the maximum
    random_phase(1'b0, 200, 8, 8, 44);
    random_phase(1'b1, 192, 3, 3, 44);
    random_phase(1'b0, 64, 2, 40, 44);
    random_phase(1'b1, 100, 64, 2, 44);

    if (board.errors == 0) begin
      $display("voxel_morphology_dilate_erode_tb: done, clean");
    end else begin
      $display("voxel_morphology_dilate_erode_tb: done, errors");
    end
    $finish;
  end

endmodule
